// ----- rtl/core/rrd_pkg.sv -----
// Shared types and constants for the round-robin time-slice dispatcher.
// No dependencies; used by rrd_sched and round_robin_time_slice_dispatcher_top.
package rrd_pkg;

	localparam int BURST_W = 16;
	localparam int TIME_W  = 24;
	localparam int JOBID_W = 3;
	localparam int OUT_W   = 72;

	localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};
	localparam logic [BURST_W-1:0] SLICE_RESET = 16'd4;

	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	typedef struct packed {
		logic               op;
		logic [BURST_W-1:0] burst;
	} item_t;

	typedef struct packed {
		logic               has_result;
		logic [JOBID_W-1:0] job_id;
		logic [BURST_W-1:0] run_length;
		logic               finished;
		logic [TIME_W-1:0]  waiting_time;
		logic [TIME_W-1:0]  elapsed_time;
	} sched_res_t;

endpackage

// ----- rtl/core/round_robin_time_slice_dispatcher_top.sv -----
// Top level of the round-robin time-slice dispatcher: stream ports, input and
// result registers, time slice register. Depends on rrd_pkg and rrd_sched.
//
//  channel   | ports                         | contents
//  ----------+-------------------------------+------------------------------------
//  input     | s_axis_tvalid/tready/tdata/tuser | tuser operation, tdata burst_length
//  result    | m_axis_tvalid/tready/tdata    | job, run, finished, waiting, elapsed
//  config    | cfg_wr_en/cfg_wr_data         | time_slice
//
// One item per cycle while a full, stalled result register does not hold back a dispatch:
// an accepted item waits in the input register and is applied to the queue and per-job
// register files when it fires; the result register loads at that same edge and drives m_axis_tvalid.
// Reset empties the queue, zeroes the clock and job counter, sets time_slice to 4.
// A full result register holds back only dispatches that produce a result; adds
// and empty-queue dispatches pass through it.
module round_robin_time_slice_dispatcher_top #(
	parameter int MAX_JOBS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // [15:0] burst_length
	input  logic                        s_axis_tuser,  // [0] operation
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [2:0] job_id, [18:3] run_length, [19] finished, [43:20] waiting_time,
	// [67:44] elapsed_time, [71:68] zero
	output logic [rrd_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                        cfg_wr_en,
	input  logic [rrd_pkg::BURST_W-1:0] cfg_wr_data
);

	logic                        s1_valid_q;
	rrd_pkg::item_t              item_s1;
	logic [rrd_pkg::BURST_W-1:0] time_slice_q;
	logic                        m_valid_q;
	logic [rrd_pkg::OUT_W-1:0]   m_data_q;
	rrd_pkg::sched_res_t         res;
	logic                        advance;
	logic                        fire;

	assign advance       = !res.has_result || !m_valid_q || m_axis_tready;
	assign fire          = s1_valid_q && advance;
	assign s_axis_tready = !s1_valid_q || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	rrd_sched #(
		.MAX_JOBS(MAX_JOBS)
	) u_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.time_slice (time_slice_q),
		.fire       (fire),
		.item       (item_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= rrd_pkg::SLICE_RESET;
		end else if (cfg_wr_en) begin
			time_slice_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (fire && res.has_result) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.op    <= s_axis_tuser;
			item_s1.burst <= s_axis_tdata;
		end
		if (fire && res.has_result) begin
			m_data_q <= {4'b0000, res.elapsed_time, res.waiting_time, res.finished,
				res.run_length, res.job_id};
		end
	end

endmodule

// ----- rtl/core/rrd_sched.sv -----
// Scheduling state of the dispatcher: circular run queue, per-job register files
// and the elapsed clock. One item is applied per cycle when fire is high.
// Depends on rrd_pkg.
module rrd_sched #(
	parameter int MAX_JOBS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rrd_pkg::BURST_W-1:0] time_slice,
	input  logic                        fire,
	input  rrd_pkg::item_t              item,
	output rrd_pkg::sched_res_t         res
);

	localparam int IDW = $clog2(MAX_JOBS);
	localparam int CW  = $clog2(MAX_JOBS + 1);

	logic [IDW-1:0]              rq_q   [MAX_JOBS];
	logic [rrd_pkg::BURST_W-1:0] rem_q  [MAX_JOBS];
	logic [rrd_pkg::TIME_W-1:0]  last_q [MAX_JOBS];
	logic [rrd_pkg::TIME_W-1:0]  wait_q [MAX_JOBS];

	logic [IDW-1:0]             head_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              added_q;
	logic [rrd_pkg::TIME_W-1:0] clock_q;

	logic [CW:0]                 tail_sum;
	logic [IDW-1:0]              tail_idx;
	logic [IDW-1:0]              head_inc;
	logic [IDW-1:0]              disp_id;
	logic [IDW-1:0]              new_id;
	logic [rrd_pkg::BURST_W-1:0] rem;
	logic                        more;
	logic [rrd_pkg::BURST_W-1:0] run;
	logic [rrd_pkg::TIME_W-1:0]  waited;
	logic [rrd_pkg::TIME_W:0]    wsum;
	logic [rrd_pkg::TIME_W-1:0]  new_wait;
	logic [rrd_pkg::TIME_W:0]    csum;
	logic [rrd_pkg::TIME_W-1:0]  new_clock;
	logic                        can_add;
	logic                        do_add;
	logic                        do_disp;

	always_comb begin
		tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
		// head + count stays below twice the depth: one compare and subtract wraps it
		if (tail_sum >= (CW+1)'(MAX_JOBS)) begin
			tail_idx = IDW'(tail_sum - (CW+1)'(MAX_JOBS));
		end else begin
			tail_idx = IDW'(tail_sum);
		end
		head_inc = (head_q == IDW'(MAX_JOBS - 1)) ? '0 : head_q + IDW'(1);
		disp_id  = rq_q[head_q];
		new_id   = IDW'(added_q);
		rem      = rem_q[disp_id];
		more     = rem > time_slice;
		run      = more ? time_slice : rem;
		waited   = clock_q - last_q[disp_id];
		wsum     = {1'b0, wait_q[disp_id]} + {1'b0, waited};
		new_wait = wsum[rrd_pkg::TIME_W] ? rrd_pkg::TIME_MAX : wsum[rrd_pkg::TIME_W-1:0];
		csum      = {1'b0, clock_q} + (rrd_pkg::TIME_W+1)'(run);
		new_clock = csum[rrd_pkg::TIME_W] ? rrd_pkg::TIME_MAX : csum[rrd_pkg::TIME_W-1:0];
		can_add  = (added_q < CW'(MAX_JOBS)) && (count_q < CW'(MAX_JOBS));
		do_add   = fire && (item.op == rrd_pkg::OP_ADD) && can_add;
		do_disp  = fire && res.has_result;
	end

	always_comb begin
		res.has_result   = (item.op == rrd_pkg::OP_DISPATCH) && (count_q != '0);
		res.job_id       = rrd_pkg::JOBID_W'(disp_id);
		res.run_length   = run;
		res.finished     = !more;
		res.waiting_time = new_wait;
		res.elapsed_time = new_clock;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			added_q <= '0;
			clock_q <= '0;
		end else if (do_add) begin
			count_q <= count_q + CW'(1);
			added_q <= added_q + CW'(1);
		end else if (do_disp) begin
			head_q  <= head_inc;
			clock_q <= new_clock;
			// an unfinished job takes the slot it just freed at the tail
			if (!more) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_add) begin
			rq_q[tail_idx] <= new_id;
			rem_q[new_id]  <= item.burst;
			last_q[new_id] <= clock_q;
			wait_q[new_id] <= '0;
		end else if (do_disp) begin
			wait_q[disp_id] <= new_wait;
			last_q[disp_id] <= new_clock;
			rem_q[disp_id]  <= more ? rem - time_slice : '0;
			if (more) begin
				rq_q[tail_idx] <= disp_id;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_JOBS))
		else $error("run queue count exceeds depth");

	a_count_le_added: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= added_q)
		else $error("more queued jobs than jobs ever added");

	a_clock_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		clock_q >= $past(clock_q))
		else $error("elapsed clock went backwards");

	a_finish_pops: assert property (@(posedge clk) disable iff (!arst_n)
		do_disp && !more |=> count_q == $past(count_q) - CW'(1))
		else $error("finished job did not leave the queue");

endmodule

// ----- verif/tb_round_robin_time_slice_dispatcher_top.sv -----
// Self-checking testbench for round_robin_time_slice_dispatcher_top: a directed table, then random
// phases with varied time slices and idle patterns, checked against a cycle-free job-queue predictor.
// Depends on rrd_pkg and the dispatcher RTL only.
module tb_round_robin_time_slice_dispatcher_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rrd_pkg::*;

	localparam int JOBS            = 8;
	localparam int ITEMS_PER_PHASE = 360;
	localparam int SETTLE_CYCLES   = 6;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int MAX_REPORTS     = 40;

	// One dispatch result, laid out as in m_axis_tdata.
	typedef struct packed {
		logic [TIME_W-1:0]  elapsed_time;
		logic [TIME_W-1:0]  waiting_time;
		logic               finished;
		logic [BURST_W-1:0] run_length;
		logic [JOBID_W-1:0] job_id;
	} dispatch_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_TYPED, ROW_SLICE} row_kind_e;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	typedef struct packed {
		row_kind_e          kind;
		logic               op;
		logic [BURST_W-1:0] value;
		dispatch_t          want;
	} stim_row_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [BURST_W-1:0] s_axis_tdata  = '0;
	logic               s_axis_tuser  = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               cfg_wr_en     = 1'b0;
	logic [BURST_W-1:0] cfg_wr_data   = '0;

	int        sender_pct  = 0;
	int        stall_pct   = 0;
	logic      hold_off    = 1'b0;
	int        error_count = 0;
	int        cycle_count = 0;
	dispatch_t dispatches_due [$];
	stim_row_t directed [$];

	// Predictor state
	logic [BURST_W-1:0] slice;
	logic [JOBID_W-1:0] ring [JOBS];
	logic [JOBID_W-1:0] ring_head;
	logic [3:0]         ring_count;
	logic [3:0]         jobs_added;
	logic [BURST_W-1:0] time_left [JOBS];
	logic [TIME_W-1:0]  last_end [JOBS];
	logic [TIME_W-1:0]  wait_sum [JOBS];
	logic [TIME_W-1:0]  clock_total;

	round_robin_time_slice_dispatcher_top #(.MAX_JOBS(JOBS)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	endfunction

	// Apply one accepted transaction to the job queue and return the dispatch it causes.
	function automatic void schedule_item(input logic op, input logic [BURST_W-1:0] burst,
		output logic produced, output dispatch_t res);
		logic [JOBID_W-1:0] id;
		logic [BURST_W-1:0] run;
		logic               fin;
		produced = 1'b0;
		res      = '0;
		if (op == OP_ADD) begin
			if (jobs_added < JOBS && ring_count < JOBS) begin
				id            = jobs_added[JOBID_W-1:0];
				time_left[id] = burst;
				last_end[id]  = clock_total;
				wait_sum[id]  = '0;
				ring[ring_head + ring_count[JOBID_W-1:0]] = id;
				ring_count++;
				jobs_added++;
			end
		end else if (ring_count != 0) begin
			id = ring[ring_head];
			ring_head++;
			ring_count--;
			wait_sum[id] = sat_add(wait_sum[id], clock_total - last_end[id]);
			if (time_left[id] > slice) begin
				run           = slice;
				time_left[id] = time_left[id] - slice;
				fin           = 1'b0;
			end else begin
				run           = time_left[id];
				time_left[id] = '0;
				fin           = 1'b1;
			end
			clock_total  = sat_add(clock_total, TIME_W'(run));
			last_end[id] = clock_total;
			// requeue at the tail when time is left
			if (!fin) begin
				ring[ring_head + ring_count[JOBID_W-1:0]] = id;
				ring_count++;
			end
			produced         = 1'b1;
			res.job_id       = id;
			res.run_length   = run;
			res.finished     = fin;
			res.waiting_time = wait_sum[id];
			res.elapsed_time = clock_total;
		end
	endfunction

	function automatic stim_row_t mk_row(input row_kind_e kind, input logic op,
		input logic [BURST_W-1:0] value, input int job = 0, input int run = 0,
		input int fin = 0, input int waited = 0, input int elapsed = 0);
		stim_row_t r;
		r.kind              = kind;
		r.op                = op;
		r.value             = value;
		r.want.job_id       = JOBID_W'(job);
		r.want.run_length   = BURST_W'(run);
		r.want.finished     = fin[0];
		r.want.waiting_time = TIME_W'(waited);
		r.want.elapsed_time = TIME_W'(elapsed);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
	endtask

	task automatic send_item(input logic op, input logic [BURST_W-1:0] burst,
		input row_kind_e kind, input dispatch_t want, output logic produced);
		dispatch_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= burst;
		do @(posedge clk); while (!s_axis_tready);
		schedule_item(op, burst, produced, res);
		if (kind == ROW_TYPED)
			dispatches_due.push_back(want);
		else if (kind == ROW_PREDICT && produced)
			dispatches_due.push_back(res);
	endtask

	// Drop tvalid, wait for every pending dispatch, then let in-flight adds settle.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (dispatches_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slice(input logic [BURST_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		slice = value;
	endtask

	task automatic stall_receiver(input int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off = 1'b0;
	endtask

	task automatic apply_mode(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				sender_pct = 0;
				stall_pct  = 0;
			end
			IDLE_SENDER: begin
				sender_pct = 58;
				stall_pct  = 0;
			end
			IDLE_RECEIVER: begin
				sender_pct = 0;
				stall_pct  = 58;
			end
			default: begin
				sender_pct = 15;
				stall_pct  = 15;
			end
		endcase
	endtask

	always @(negedge clk)
		m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		dispatch_t got;
		dispatch_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(dispatch_t)-1:0];
			if (dispatches_due.size() == 0) begin
				report_mismatch("result with nothing pending, job_id", got.job_id, -1);
			end else begin
				want = dispatches_due.pop_front();
				if (got.job_id != want.job_id)
					report_mismatch("job_id", got.job_id, want.job_id);
				if (got.run_length != want.run_length)
					report_mismatch("run_length", got.run_length, want.run_length);
				if (got.finished != want.finished)
					report_mismatch("finished", got.finished, want.finished);
				if (got.waiting_time != want.waiting_time)
					report_mismatch("waiting_time", got.waiting_time, want.waiting_time);
				if (got.elapsed_time != want.elapsed_time)
					report_mismatch("elapsed_time", got.elapsed_time, want.elapsed_time);
			end
		end
	end

	initial begin
		logic        produced;
		logic        op;
		int          done;
		logic        paused;
		idle_mode_e  mode;
		logic [15:0] phase_slice;

		slice       = SLICE_RESET;
		ring_head   = '0;
		ring_count  = '0;
		jobs_added  = '0;
		clock_total = '0;
		for (int j = 0; j < JOBS; j++) begin
			ring[j]      = '0;
			time_left[j] = '0;
			last_end[j]  = '0;
			wait_sum[j]  = '0;
		end

		// empty queue, zero burst, slice boundaries, late arrival, full job table, zero slice
		directed.push_back(mk_row(ROW_NONE,    OP_DISPATCH, 16'hFFFF));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'h0000));
		directed.push_back(mk_row(ROW_TYPED,   OP_DISPATCH, 16'h0000, 0, 0, 1, 0, 0));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'd4));
		directed.push_back(mk_row(ROW_TYPED,   OP_DISPATCH, 16'h5A5A, 1, 4, 1, 0, 4));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'd5));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'hFFFF));
		directed.push_back(mk_row(ROW_TYPED,   OP_DISPATCH, 16'h0000, 2, 4, 0, 0, 8));
		directed.push_back(mk_row(ROW_TYPED,   OP_DISPATCH, 16'h0000, 3, 4, 0, 4, 12));
		directed.push_back(mk_row(ROW_TYPED,   OP_DISPATCH, 16'h0000, 2, 1, 1, 4, 13));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'hAAAA));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'h5555));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'h8001));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'h7FFE));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'h1234));
		directed.push_back(mk_row(ROW_SLICE,   OP_ADD,      16'h0000));
		directed.push_back(mk_row(ROW_TYPED,   OP_DISPATCH, 16'hA5A5, 3, 0, 0, 5, 13));
		directed.push_back(mk_row(ROW_PREDICT, OP_DISPATCH, 16'h0000));
		directed.push_back(mk_row(ROW_SLICE,   OP_ADD,      16'd3));
		directed.push_back(mk_row(ROW_PREDICT, OP_DISPATCH, 16'hFFFF));
		directed.push_back(mk_row(ROW_PREDICT, OP_DISPATCH, 16'h0000));
		directed.push_back(mk_row(ROW_NONE,    OP_ADD,      16'hFFFF));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_SLICE)
				write_slice(directed[i].value);
			else
				send_item(directed[i].op, directed[i].value, directed[i].kind,
					directed[i].want, produced);
		end

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					phase_slice = 16'd1;
					mode        = IDLE_NONE;
				end
				1: begin
					phase_slice = BURST_W'($urandom_range(2, 100));
					mode        = IDLE_SENDER;
				end
				2: begin
					phase_slice = 16'd0;
					mode        = IDLE_RECEIVER;
				end
				default: begin
					phase_slice = BURST_W'($urandom_range(1, 20));
					mode        = IDLE_BOTH;
				end
			endcase
			write_slice(phase_slice);
			apply_mode(mode);
			// back up the result side while items keep coming
			if (mode == IDLE_RECEIVER)
				fork
					stall_receiver(HOLD_OFF_CYCLES);
				join_none
			done   = 0;
			paused = 1'b0;
			while (done < ITEMS_PER_PHASE && ring_count != 0) begin
				if (mode == IDLE_SENDER && !paused && done >= ITEMS_PER_PHASE / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				op = ($urandom_range(0, 9) == 0) ? OP_ADD : OP_DISPATCH;
				send_item(op, BURST_W'($urandom), ROW_PREDICT, '0, produced);
				if (produced)
					done++;
			end
		end

		// widest slice: every job left finishes on its next run, then the queue runs dry
		write_slice(16'hFFFF);
		apply_mode(IDLE_NONE);
		while (ring_count != 0)
			send_item(OP_DISPATCH, BURST_W'($urandom), ROW_PREDICT, '0, produced);
		send_item(OP_DISPATCH, BURST_W'($urandom), ROW_PREDICT, '0, produced);
		send_item(OP_ADD, BURST_W'($urandom), ROW_PREDICT, '0, produced);

		wait_drained();
		if (dispatches_due.size() != 0)
			report_mismatch("results still pending", 0, dispatches_due.size());
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
